/* hw/rtl/flsrs_pkg.sv */
// ----------------------------------------------------------------------------
// flsrs_pkg
// Shared types and codes of the fixed-length sequence radix sorter.
// ----------------------------------------------------------------------------
package flsrs_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SEQ_COUNT  = 2'd0;
   localparam logic [1:0] CSR_SEQ_LENGTH = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLR,
      ST_CNT_A,
      ST_CNT_B,
      ST_CNT_C,
      ST_CNT_D,
      ST_PFX_A,
      ST_PFX_B,
      ST_DST_A,
      ST_DST_B,
      ST_DST_C,
      ST_DST_D,
      ST_OUT_A,
      ST_OUT_B
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_sym;
      logic sort_init;
      logic cnt_clr_wr;
      logic sym_rd;
      logic cnt_rd_sym;
      logic cnt_inc_wr;
      logic cnt_pfx_wr;
      logic order_wr;
      logic idx_step;
      logic code_step;
      logic next_col;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_done;
      logic idx_last;
      logic code_last;
      logic col_last;
   } status_type;

endpackage

/* hw/rtl/flsrs_ram.sv */
// ----------------------------------------------------------------------------
// flsrs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module flsrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* hw/rtl/flsrs_ctrl.sv */
// ----------------------------------------------------------------------------
// flsrs_ctrl
// Sequencer of the sorter: load, per-column clear / count / prefix / scatter, emit.
// ----------------------------------------------------------------------------
module flsrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  flsrs_pkg::status_type sts,
   output flsrs_pkg::cmd_type    cmd,
   output logic                 busy
);
   import flsrs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // order list address is always presented; the A states wait on a registered read
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_sym = 1'b1;
               if (sts.load_done) begin
                  cmd.sort_init = 1'b1;
                  state_in      = ST_CLR;
               end
            end
         end
         ST_CLR: begin
            cmd.cnt_clr_wr = 1'b1;
            cmd.code_step  = 1'b1;
            if (sts.code_last) begin
               state_in = ST_CNT_A;
            end
         end
         ST_CNT_A: begin
            state_in = ST_CNT_B;
         end
         ST_CNT_B: begin
            cmd.sym_rd = 1'b1;
            state_in   = ST_CNT_C;
         end
         ST_CNT_C: begin
            cmd.cnt_rd_sym = 1'b1;
            state_in       = ST_CNT_D;
         end
         ST_CNT_D: begin
            cmd.cnt_inc_wr = 1'b1;
            cmd.idx_step   = 1'b1;
            state_in       = sts.idx_last ? ST_PFX_A : ST_CNT_A;
         end
         ST_PFX_A: begin
            state_in = ST_PFX_B;
         end
         ST_PFX_B: begin
            cmd.cnt_pfx_wr = 1'b1;
            cmd.code_step  = 1'b1;
            state_in       = sts.code_last ? ST_DST_A : ST_PFX_A;
         end
         ST_DST_A: begin
            state_in = ST_DST_B;
         end
         ST_DST_B: begin
            cmd.sym_rd = 1'b1;
            state_in   = ST_DST_C;
         end
         ST_DST_C: begin
            cmd.cnt_rd_sym = 1'b1;
            state_in       = ST_DST_D;
         end
         ST_DST_D: begin
            cmd.cnt_inc_wr = 1'b1;
            cmd.order_wr   = 1'b1;
            cmd.idx_step   = 1'b1;
            if (sts.idx_last) begin
               cmd.next_col = 1'b1;
               state_in     = sts.col_last ? ST_OUT_A : ST_CLR;
            end else begin
               state_in = ST_DST_A;
            end
         end
         ST_OUT_A: begin
            state_in = ST_OUT_B;
         end
         ST_OUT_B: begin
            cmd.emit     = 1'b1;
            cmd.idx_step = 1'b1;
            state_in     = sts.idx_last ? ST_IDLE : ST_OUT_A;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/flsrs_dp.sv */
// ----------------------------------------------------------------------------
// flsrs_dp
// Datapath: symbol store, bucket counts, ping-pong order list, counters.
// ----------------------------------------------------------------------------
module flsrs_dp #(
   parameter int MAX_SEQS     = 64,
   parameter int MAX_LEN      = 64,
   parameter int SYMBOL_CODES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  flsrs_pkg::cmd_type    cmd,
   output flsrs_pkg::status_type sts,
   input  logic [5:0]            req_symbol,
   input  logic                  csr_wr,
   input  logic [1:0]            csr_index,
   input  logic [6:0]            csr_wdata,
   output logic                  rsp_strobe,
   output logic [5:0]            rsp_original_index,
   output logic                  rsp_last_rank
);
   import flsrs_pkg::*;

   localparam int IW = $clog2(MAX_SEQS);
   localparam int NW = $clog2(MAX_SEQS + 1);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int KW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(SYMBOL_CODES);
   localparam int SD = MAX_SEQS * MAX_LEN;
   localparam int AW = (SD > 1) ? $clog2(SD) : 1;
   localparam int PW = IW + LW;
   localparam int OD = 2 ** (IW + 1);
   localparam int CNT_RST = (MAX_SEQS < 64) ? MAX_SEQS : 64;
   localparam int LEN_RST = (MAX_LEN < 64) ? MAX_LEN : 64;

   logic [NW-1:0] n_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] pos_ff;
   logic [IW-1:0] idx_ff;
   logic [CW-1:0] code_ff;
   logic [KW-1:0] col_ff;
   logic          bank_ff;
   logic          first_ff;
   logic [IW-1:0] seq_ff;
   logic [CW-1:0] sym_ff;
   logic [NW-1:0] run_ff;

   logic [AW:0]   total;
   logic [IW-1:0] seq_cur;
   logic [PW-1:0] sym_prod;
   logic [CW-1:0] sym_sat;
   logic [CW-1:0] sym_rdata;
   logic [NW-1:0] cnt_rdata;
   logic [IW-1:0] ord_rdata;
   logic          cnt_we;
   logic [CW-1:0] cnt_waddr;
   logic [NW-1:0] cnt_wdata;
   logic [CW-1:0] cnt_raddr;
   logic [NW-1:0] run_base;

   assign total = (AW + 1)'(n_ff) * (AW + 1)'(len_ff);

   assign sts.load_done = ((AW + 1)'(pos_ff) + 1'b1) == total;
   assign sts.idx_last  = (NW'(idx_ff) + 1'b1) == n_ff;
   assign sts.code_last = code_ff == CW'(SYMBOL_CODES - 1);
   assign sts.col_last  = col_ff == '0;

   // saturate out-of-range codes
   always_comb begin
      if (9'(req_symbol) >= 9'(SYMBOL_CODES)) begin
         sym_sat = CW'(SYMBOL_CODES - 1);
      end else begin
         sym_sat = CW'(req_symbol);
      end
   end

   assign seq_cur  = first_ff ? idx_ff : ord_rdata;
   assign sym_prod = PW'(seq_cur) * PW'(len_ff) + PW'(col_ff);
   assign run_base = (code_ff == '0) ? '0 : run_ff;

   always_comb begin
      cnt_we    = cmd.cnt_clr_wr | cmd.cnt_inc_wr | cmd.cnt_pfx_wr;
      cnt_waddr = code_ff;
      cnt_wdata = '0;
      if (cmd.cnt_inc_wr) begin
         cnt_waddr = sym_ff;
         cnt_wdata = cnt_rdata + 1'b1;
      end else if (cmd.cnt_pfx_wr) begin
         cnt_wdata = run_base;
      end
      cnt_raddr = cmd.cnt_rd_sym ? sym_rdata : code_ff;
   end

   flsrs_ram #(.WIDTH(CW), .DEPTH(SD)) u_sym_ram (
      .clock (clock),
      .we    (cmd.load_sym),
      .waddr (pos_ff),
      .wdata (sym_sat),
      .raddr (AW'(sym_prod)),
      .rdata (sym_rdata)
   );

   flsrs_ram #(.WIDTH(NW), .DEPTH(SYMBOL_CODES)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   flsrs_ram #(.WIDTH(IW), .DEPTH(OD)) u_ord_ram (
      .clock (clock),
      .we    (cmd.order_wr),
      .waddr ({~bank_ff, cnt_rdata[IW-1:0]}),
      .wdata (seq_ff),
      .raddr ({bank_ff, idx_ff}),
      .rdata (ord_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= NW'(CNT_RST);
         len_ff   <= LW'(LEN_RST);
         pos_ff   <= '0;
         idx_ff   <= '0;
         code_ff  <= '0;
         col_ff   <= '0;
         bank_ff  <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               CSR_SEQ_COUNT: begin
                  pos_ff <= '0;
                  if (csr_wdata == '0) begin
                     n_ff <= NW'(1);
                  end else if (int'(csr_wdata) > MAX_SEQS) begin
                     n_ff <= NW'(MAX_SEQS);
                  end else begin
                     n_ff <= NW'(csr_wdata);
                  end
               end
               CSR_SEQ_LENGTH: begin
                  pos_ff <= '0;
                  if (csr_wdata == '0) begin
                     len_ff <= LW'(1);
                  end else if (int'(csr_wdata) > MAX_LEN) begin
                     len_ff <= LW'(MAX_LEN);
                  end else begin
                     len_ff <= LW'(csr_wdata);
                  end
               end
               default: begin
               end
            endcase
         end else if (cmd.load_sym) begin
            pos_ff <= sts.load_done ? '0 : pos_ff + 1'b1;
         end
         if (cmd.sort_init) begin
            idx_ff   <= '0;
            code_ff  <= '0;
            col_ff   <= KW'(len_ff - 1'b1);
            bank_ff  <= 1'b0;
            first_ff <= 1'b1;
         end
         if (cmd.idx_step) begin
            idx_ff <= sts.idx_last ? '0 : idx_ff + 1'b1;
         end
         if (cmd.code_step) begin
            code_ff <= sts.code_last ? '0 : code_ff + 1'b1;
         end
         if (cmd.next_col) begin
            bank_ff  <= ~bank_ff;
            first_ff <= 1'b0;
            if (!sts.col_last) begin
               col_ff <= col_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sym_rd) begin
         seq_ff <= seq_cur;
      end
      if (cmd.cnt_rd_sym) begin
         sym_ff <= sym_rdata;
      end
      if (cmd.cnt_pfx_wr) begin
         run_ff <= run_base + cnt_rdata;
      end
   end

   assign rsp_strobe         = cmd.emit;
   assign rsp_original_index = 6'(ord_rdata);
   assign rsp_last_rank      = sts.idx_last;

endmodule

/* hw/rtl/fixed_length_sequence_radix_sort_top.sv */
// ----------------------------------------------------------------------------
// fixed_length_sequence_radix_sort_top
// Stable LSD radix sort of equal-length symbol sequences; ties keep load order.
// ----------------------------------------------------------------------------
// Usage:
//   Program seq_count (index 0) and seq_length (index 1) on the csr_ port
//   while the block is idle; csr_ready is always high. A write to either
//   register drops a partial load. Feed symbols one word per cycle on
//   req_symbol with start high while busy is low, sequence after sequence,
//   position zero first. The word that completes the set raises busy and
//   starts the sort. Each column pass runs a clear sweep and a prefix sweep
//   of the bucket counts, plus a count walk and a scatter walk over the
//   sequences, paced by the single read port of the symbol store and the
//   read-modify-write of the count memory. Results then leave one word at
//   a time on rsp_original_index with rsp_strobe high for one cycle each;
//   rsp_last_rank marks the final rank. The receiver cannot stall, so
//   results are never held back. busy falls after the last result.
//   Synchronous reset returns to idle, empties the load and sets both
//   registers to 64 clamped to the limits.
// ----------------------------------------------------------------------------
module fixed_length_sequence_radix_sort_top #(
   parameter int MAX_SEQS     = 64,
   parameter int MAX_LEN      = 64,
   parameter int SYMBOL_CODES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [5:0] req_symbol,
   output logic       rsp_strobe,
   output logic [5:0] rsp_original_index,
   output logic       rsp_last_rank,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);
   import flsrs_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // ready tied high; writes must arrive only while idle (not enforced)
   assign csr_ready = 1'b1;

   flsrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   flsrs_dp #(
      .MAX_SEQS     (MAX_SEQS),
      .MAX_LEN      (MAX_LEN),
      .SYMBOL_CODES (SYMBOL_CODES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_symbol         (req_symbol),
      .csr_wr             (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_original_index (rsp_original_index),
      .rsp_last_rank      (rsp_last_rank)
   );

endmodule
